// ===== hdl/dda_pkg.sv =====
// Shared types, codes and constants for the styled DDA line rasterizer.
package dda_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    // Function codes of an input word
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Style codes
    localparam logic [2:0] STYLE_SOLID   = 3'd0;
    localparam logic [2:0] STYLE_DASH    = 3'd1;
    localparam logic [2:0] STYLE_DOT     = 3'd2;
    localparam logic [2:0] STYLE_DASHDOT = 3'd3;
    localparam logic [2:0] STYLE_ERASE   = 3'd4;

    // Palette colors
    localparam logic [3:0] COLOR_WHITE = 4'd15;
    localparam logic [3:0] COLOR_GRAY  = 4'd7;
    localparam logic [3:0] COLOR_BLACK = 4'd0;

    // Pattern counter limits
    localparam logic [3:0] PAT_FIRST      = 4'd1;
    localparam logic [3:0] DASH_PERIOD    = 4'd15;
    localparam logic [3:0] DASH_GAP_START = 4'd5;
    localparam logic [3:0] DOT_PERIOD     = 4'd2;
    localparam logic [3:0] DDOT_PERIOD    = 4'd7;
    localparam logic [3:0] DDOT_GAP       = 4'd5;

    // Line setup sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XGO,
        ST_XWAIT,
        ST_YGO,
        ST_YWAIT
    } state_t;

endpackage

// ===== hdl/dda_div.sv =====
// Bit-serial restoring divider for the fixed-point per-axis increments.
module dda_div
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] num,
    input  logic [COORD_BITS-1:0] den,
    output logic                  done,
    output logic [FRAC_BITS:0]    quo
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [FRAC_BITS:0]    quo_reg, quo_next;
    logic [COORD_BITS-1:0] den_reg, den_next;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   dvs;
    logic                  ge;

    // Shared compare-subtract: one quotient bit per cycle, integer bit first
    always_comb
    begin
        dvs   = {1'b0, (start ? den : den_reg)};
        trial = start ? {1'b0, num} : {rem_reg[COORD_BITS-1:0], 1'b0};
        ge    = (trial >= dvs);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(FRAC_BITS);
            den_next  = den;
            rem_next  = ge ? (trial - dvs) : trial;
            quo_next  = {{FRAC_BITS{1'b0}}, ge};
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (trial - dvs) : trial;
            quo_next = {quo_reg[FRAC_BITS-1:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold iteration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/dda_pat.sv =====
// Style decoder: color, draw flag and next pattern count.
module dda_pat
    import dda_pkg::*;
(
    input  logic [2:0] style,
    input  logic [3:0] count,
    output logic [3:0] color,
    output logic       draw,
    output logic [3:0] count_next
);

    // Pick the color for the style
    always_comb
    begin
        unique case (style) inside
            STYLE_DASH, STYLE_DOT, STYLE_DASHDOT: color = COLOR_GRAY;
            STYLE_ERASE:                          color = COLOR_BLACK;
            default:                              color = COLOR_WHITE;
        endcase
    end

    // Decode the on/off pattern and advance the counter
    always_comb
    begin
        unique case (style)
            STYLE_DASH:
            begin
                draw       = (count < DASH_GAP_START);
                count_next = (count >= DASH_PERIOD) ? PAT_FIRST : count + 4'd1;
            end
            STYLE_DOT:
            begin
                draw       = (count < DOT_PERIOD);
                count_next = (count < DOT_PERIOD) ? count + 4'd1 : PAT_FIRST;
            end
            STYLE_DASHDOT:
            begin
                draw       = (count < DDOT_PERIOD) && (count != DDOT_GAP);
                count_next = (count >= DDOT_PERIOD) ? PAT_FIRST : count + 4'd1;
            end
            default:
            begin
                draw       = 1'b1;
                count_next = count;
            end
        endcase
    end

endmodule

// ===== hdl/dda_styled_line_rasterizer_core.sv =====
// Top level of the styled DDA line rasterizer.
//
// Input channel (in_valid/in_stall): func = 0 starts a line from
// (x_start, y_start) to (x_end, y_end) in the given style and yields no
// word; func = 1 asks for the next pixel and yields exactly one word.
// Output channel (out_valid/out_stall): pixel_x, pixel_y, color, draw,
// last and idle. A step with no line in progress yields idle = 1.
// A step word is registered and its pixel shows on the output in the next
// cycle, so pixels stream at one per cycle while out_stall is low.
// A start word runs the per-axis increments through one bit-serial divider,
// x then y, one quotient bit per cycle: the input stalls after a start
// through XGO, XWAIT, YGO and YWAIT, or not at all for a zero-length line.
// When out_stall holds a pixel, in_stall rises and the pending pixel holds
// until taken. Reset clears the line state: no line active, pattern count 1,
// output empty.
module dda_styled_line_rasterizer_core
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic [2:0]            style,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [3:0]            color,
    output logic                  draw,
    output logic                  last,
    output logic                  idle
);

    localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;

    state_t state_reg, state_next;

    logic signed [ACC_W-1:0] x_acc_reg, x_acc_next;
    logic signed [ACC_W-1:0] y_acc_reg, y_acc_next;
    logic signed [ACC_W-1:0] x_inc_reg, x_inc_next;
    logic signed [ACC_W-1:0] y_inc_reg, y_inc_next;
    logic [COORD_BITS-1:0]   left_reg, left_next;
    logic [COORD_BITS-1:0]   steps_reg, steps_next;
    logic [COORD_BITS-1:0]   x_mag_reg, x_mag_next;
    logic [COORD_BITS-1:0]   y_mag_reg, y_mag_next;
    logic                    x_neg_reg, x_neg_next;
    logic                    y_neg_reg, y_neg_next;
    logic [3:0]              pat_reg, pat_next;
    logic [2:0]              style_reg, style_next;
    logic                    active_reg, active_next;

    logic                    ovalid_reg, ovalid_next;
    logic [COORD_BITS-1:0]   px_reg, px_next;
    logic [COORD_BITS-1:0]   py_reg, py_next;
    logic [3:0]              color_reg, color_next;
    logic                    draw_reg, draw_next;
    logic                    last_reg, last_next;
    logic                    idle_reg, idle_next;

    logic                    in_take;
    logic                    out_take;
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]   adx, ady;
    logic                    div_start;
    logic [COORD_BITS-1:0]   div_num;
    logic                    div_done;
    logic [FRAC_BITS:0]      div_quo;
    logic signed [ACC_W-1:0] quo_ext;
    logic [3:0]              pat_color;
    logic                    pat_draw;
    logic [3:0]              pat_count_next;

    // Shared increment divider
    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (steps_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Style pattern decode
    dda_pat u_pat (
        .style      (style_reg),
        .count      (pat_reg),
        .color      (pat_color),
        .draw       (pat_draw),
        .count_next (pat_count_next)
    );

    // Handshakes
    assign out_take  = ovalid_reg && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (ovalid_reg && out_stall);
    assign in_take   = in_valid && !in_stall;

    // Endpoint deltas and their magnitudes
    assign dx  = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    assign dy  = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

    assign div_start = (state_reg == ST_XGO) || (state_reg == ST_YGO);
    assign div_num   = (state_reg == ST_YGO) ? y_mag_reg : x_mag_reg;
    assign quo_ext   = $signed({{(ACC_W-FRAC_BITS-1){1'b0}}, div_quo});

    // Sequence line setup and pixel stepping
    always_comb
    begin
        state_next  = state_reg;
        x_acc_next  = x_acc_reg;
        y_acc_next  = y_acc_reg;
        x_inc_next  = x_inc_reg;
        y_inc_next  = y_inc_reg;
        left_next   = left_reg;
        steps_next  = steps_reg;
        x_mag_next  = x_mag_reg;
        y_mag_next  = y_mag_reg;
        x_neg_next  = x_neg_reg;
        y_neg_next  = y_neg_reg;
        pat_next    = pat_reg;
        style_next  = style_reg;
        active_next = active_reg;

        ovalid_next = out_take ? 1'b0 : ovalid_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        color_next  = color_reg;
        draw_next   = draw_reg;
        last_next   = last_reg;
        idle_next   = idle_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (func == FUNC_START))
                begin
                    // Load a new line, dropping any old one
                    x_acc_next  = $signed({2'b00, x_start, {FRAC_BITS{1'b0}}});
                    y_acc_next  = $signed({2'b00, y_start, {FRAC_BITS{1'b0}}});
                    x_inc_next  = '0;
                    y_inc_next  = '0;
                    x_mag_next  = adx;
                    y_mag_next  = ady;
                    x_neg_next  = dx[COORD_BITS];
                    y_neg_next  = dy[COORD_BITS];
                    steps_next  = (adx > ady) ? adx : ady;
                    left_next   = (adx > ady) ? adx : ady;
                    pat_next    = PAT_FIRST;
                    style_next  = style;
                    active_next = 1'b1;
                    if ((adx != '0) || (ady != '0))
                    begin
                        state_next = ST_XGO;
                    end
                end
                else if (in_take)
                begin
                    // Emit one pixel word
                    ovalid_next = 1'b1;
                    if (!active_reg)
                    begin
                        px_next    = '0;
                        py_next    = '0;
                        color_next = COLOR_BLACK;
                        draw_next  = 1'b0;
                        last_next  = 1'b0;
                        idle_next  = 1'b1;
                    end
                    else
                    begin
                        px_next    = x_acc_reg[FRAC_BITS +: COORD_BITS];
                        py_next    = y_acc_reg[FRAC_BITS +: COORD_BITS];
                        color_next = pat_color;
                        draw_next  = pat_draw;
                        idle_next  = 1'b0;
                        pat_next   = pat_count_next;
                        if (left_reg == '0)
                        begin
                            last_next   = 1'b1;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            last_next  = 1'b0;
                            left_next  = left_reg - 1'b1;
                            x_acc_next = x_acc_reg + x_inc_reg;
                            y_acc_next = y_acc_reg + y_inc_reg;
                        end
                    end
                end
            end
            ST_XGO:
            begin
                state_next = ST_XWAIT;
            end
            ST_XWAIT:
            begin
                if (div_done)
                begin
                    x_inc_next = x_neg_reg ? -quo_ext : quo_ext;
                    state_next = ST_YGO;
                end
            end
            ST_YGO:
            begin
                state_next = ST_YWAIT;
            end
            ST_YWAIT:
            begin
                if (div_done)
                begin
                    y_inc_next = y_neg_reg ? -quo_ext : quo_ext;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            x_acc_reg  <= '0;
            y_acc_reg  <= '0;
            x_inc_reg  <= '0;
            y_inc_reg  <= '0;
            left_reg   <= '0;
            pat_reg    <= PAT_FIRST;
            style_reg  <= STYLE_SOLID;
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            x_acc_reg  <= x_acc_next;
            y_acc_reg  <= y_acc_next;
            x_inc_reg  <= x_inc_next;
            y_inc_reg  <= y_inc_next;
            left_reg   <= left_next;
            pat_reg    <= pat_next;
            style_reg  <= style_next;
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Hold setup operands and the output word
    always_ff @(posedge clk)
    begin
        steps_reg <= steps_next;
        x_mag_reg <= x_mag_next;
        y_mag_reg <= y_mag_next;
        x_neg_reg <= x_neg_next;
        y_neg_reg <= y_neg_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        color_reg <= color_next;
        draw_reg  <= draw_next;
        last_reg  <= last_next;
        idle_reg  <= idle_next;
    end

    assign out_valid = ovalid_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign color     = color_reg;
    assign draw      = draw_reg;
    assign last      = last_reg;
    assign idle      = idle_reg;

endmodule

// ===== sim/dda_styled_line_rasterizer_core_tb.sv =====
// Self-checking testbench for the styled DDA line rasterizer core.
module testbench;
    import dda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_FIRST = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT = 2000;
    localparam int COORD_MAX = (1 << CB) - 1;

    // Style codes left undefined by the block; they draw solid white
    localparam logic [2:0] STYLE_SPARE = 3'd7;

    typedef struct {
        logic          func;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
        logic [2:0]    sty;
    } line_word_t;

    typedef struct {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic [3:0]    color;
        logic          draw;
        logic          last;
        logic          idle;
    } pixel_word_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          func = FUNC_STEP;
    logic [CB-1:0] x_start = '0;
    logic [CB-1:0] y_start = '0;
    logic [CB-1:0] x_end = '0;
    logic [CB-1:0] y_end = '0;
    logic [2:0]    style = STYLE_SOLID;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic [3:0]    color;
    logic          draw;
    logic          last;
    logic          idle;

    // Words waiting to be sent and pixels waiting to come back
    line_word_t  line_words_q[$];
    pixel_word_t pixel_q[$];

    int n_total = 0;
    int n_sent = 0;
    int n_err = 0;

    // Predicted rasterizer state
    longint     x_acc = 0;
    longint     y_acc = 0;
    longint     x_inc = 0;
    longint     y_inc = 0;
    longint     steps_to_go = 0;
    logic [3:0] pat_count = PAT_FIRST;
    logic [2:0] line_style = STYLE_SOLID;
    bit         line_on = 1'b0;

    dda_styled_line_rasterizer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .style     (style),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .color     (color),
        .draw      (draw),
        .last      (last),
        .idle      (idle)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Per-axis increment: |delta| / steps in fixed point, truncated toward zero
    function automatic longint fixed_increment(longint delta, longint nsteps);
        longint mag;
        longint q;
        if (nsteps == 0)
            return 0;
        mag = (delta < 0) ? -delta : delta;
        q = (mag <<< FB) / nsteps;
        return (delta < 0) ? -q : q;
    endfunction

    // Apply the word on the input ports to the predicted state
    function automatic void rasterize_word();
        longint      dx;
        longint      dy;
        longint      adx;
        longint      ady;
        longint      nsteps;
        pixel_word_t p;
        if (func == FUNC_START)
        begin
            dx = longint'(x_end) - longint'(x_start);
            dy = longint'(y_end) - longint'(y_start);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            nsteps = (adx > ady) ? adx : ady;
            x_inc = fixed_increment(dx, nsteps);
            y_inc = fixed_increment(dy, nsteps);
            x_acc = longint'(x_start) <<< FB;
            y_acc = longint'(y_start) <<< FB;
            steps_to_go = nsteps;
            pat_count = PAT_FIRST;
            line_style = style;
            line_on = 1'b1;
            return;
        end
        p = '{default: '0};
        if (!line_on)
        begin
            p.idle = 1'b1;
        end
        else
        begin
            p.px = CB'(x_acc >>> FB);
            p.py = CB'(y_acc >>> FB);
            case (line_style) inside
                STYLE_DASH, STYLE_DOT, STYLE_DASHDOT: p.color = COLOR_GRAY;
                STYLE_ERASE:                          p.color = COLOR_BLACK;
                default:                              p.color = COLOR_WHITE;
            endcase
            // Draw flag from the pattern count, then advance the count
            case (line_style)
                STYLE_DASH:
                begin
                    p.draw = (pat_count < DASH_GAP_START);
                    pat_count = (pat_count >= DASH_PERIOD) ? PAT_FIRST : pat_count + 4'd1;
                end
                STYLE_DOT:
                begin
                    p.draw = (pat_count < DOT_PERIOD);
                    pat_count = (pat_count < DOT_PERIOD) ? pat_count + 4'd1 : PAT_FIRST;
                end
                STYLE_DASHDOT:
                begin
                    p.draw = (pat_count < DDOT_PERIOD) && (pat_count != DDOT_GAP);
                    pat_count = (pat_count >= DDOT_PERIOD) ? PAT_FIRST : pat_count + 4'd1;
                end
                default:
                    p.draw = 1'b1;
            endcase
            if (steps_to_go == 0)
            begin
                p.last = 1'b1;
                line_on = 1'b0;
            end
            else
            begin
                steps_to_go--;
                x_acc += x_inc;
                y_acc += y_inc;
            end
        end
        pixel_q.push_back(p);
    endfunction

    task automatic add_start(int x0, int y0, int x1, int y1, logic [2:0] sty);
        line_word_t w;
        w.func = FUNC_START;
        w.xs = CB'(x0);
        w.ys = CB'(y0);
        w.xe = CB'(x1);
        w.ye = CB'(y1);
        w.sty = sty;
        line_words_q.push_back(w);
        n_total++;
    endtask

    // Step words carry random junk in the endpoint fields
    task automatic add_steps(int n);
        line_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.func = FUNC_STEP;
            w.xs = CB'($urandom);
            w.ys = CB'($urandom);
            w.xe = CB'($urandom);
            w.ye = CB'($urandom);
            w.sty = 3'($urandom);
            line_words_q.push_back(w);
            n_total++;
        end
    endtask

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Sender: bursts of words with random gaps, payload held while stalled
    int gap_left = 0;
    int burst_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : driver
        line_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                rasterize_word();
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (line_words_q.size() > 0)
                begin
                    w = line_words_q.pop_front();
                    func <= w.func;
                    x_start <= w.xs;
                    y_start <= w.ys;
                    x_end <= w.xe;
                    y_end <= w.ye;
                    style <= w.sty;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left <= $urandom_range(60, 200);
                            gap_left <= 0;
                        end
                        else
                        begin
                            burst_left <= $urandom_range(1, 25);
                            gap_left <= $urandom_range(1, 8);
                        end
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall modes that change over time, plus long hold-offs
    int rx_taken = 0;
    int hold_left = 0;
    int next_hold = HOLD_FIRST;
    int rx_mode = 0;
    int mode_left = 0;
    int pat_phase = 0;
    logic [7:0] stall_pat = 8'h00;

    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_taken <= 0;
            hold_left <= 0;
            next_hold <= HOLD_FIRST;
            rx_mode <= 0;
            mode_left <= 0;
            pat_phase <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                rx_taken <= rx_taken + 1;
            pat_phase <= (pat_phase + 1) % 8;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= (hold_left > 1);
            end
            else if (rx_taken >= next_hold)
            begin
                // hold off so the core fills up and backs up its input
                hold_left <= HOLD_CYCLES;
                next_hold <= next_hold + 2 * HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode <= $urandom_range(0, 2);
                    mode_left <= $urandom_range(20, 200);
                    stall_pat <= 8'($urandom);
                end
                else
                begin
                    mode_left <= mode_left - 1;
                end
                case (rx_mode)
                    1:       out_stall <= ($urandom_range(0, 99) < 35);
                    2:       out_stall <= stall_pat[pat_phase];
                    default: out_stall <= 1'b0;
                endcase
            end
        end
    end

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            n_err++;
        end
    endfunction

    // Monitor: compare each taken pixel word with the oldest prediction
    always @(posedge clk)
    begin : monitor
        pixel_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("unexpected pixel word: x %0d y %0d idle %0d", pixel_x, pixel_y, idle);
                n_err++;
            end
            else
            begin
                e = pixel_q.pop_front();
                check_field("pixel_x", e.px, pixel_x);
                check_field("pixel_y", e.py, pixel_y);
                check_field("color", e.color, color);
                check_field("draw", e.draw, draw);
                check_field("last", e.last, last);
                check_field("idle", e.idle, idle);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int x0;
        int y0;
        int x1;
        int y1;
        int len;
        int n;
        int kind;

        // Steps before any line report idle
        add_steps(2);
        // Zero-length line, then a step past its end
        add_start(0, 0, 0, 0, STYLE_SOLID);
        add_steps(2);
        // Full-range diagonal, dropped by a new start while active
        add_start(0, 0, COORD_MAX, COORD_MAX, STYLE_DASH);
        add_steps(3);
        add_start(COORD_MAX, COORD_MAX, 0, 0, STYLE_DASHDOT);
        add_steps(3);
        // Undefined style draws solid white
        add_start(COORD_MAX, 0, 0, 5, STYLE_SPARE);
        add_steps(2);
        add_start(3, 9, 0, 1, STYLE_DOT);
        add_steps(3);
        add_start(512, 511, 512, 511, STYLE_ERASE);
        add_steps(2);

        // Mostly whole lines with random content, some cut short, some stray steps
        while (n_total < RANDOM_WORDS + 23)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 6)
            begin
                add_steps($urandom_range(1, 3));
            end
            else
            begin
                x0 = $urandom_range(0, COORD_MAX);
                y0 = $urandom_range(0, COORD_MAX);
                if (kind < 14)
                begin
                    x1 = $urandom_range(0, COORD_MAX);
                    y1 = $urandom_range(0, COORD_MAX);
                end
                else if (kind < 20)
                begin
                    x1 = x0;
                    y1 = y0;
                end
                else
                begin
                    x1 = clamp_coord(x0 + $urandom_range(0, 80) - 40);
                    y1 = clamp_coord(y0 + $urandom_range(0, 80) - 40);
                end
                len = (x1 > x0) ? x1 - x0 : x0 - x1;
                if (((y1 > y0) ? y1 - y0 : y0 - y1) > len)
                    len = (y1 > y0) ? y1 - y0 : y0 - y1;
                n = len + 1;
                if (n > 1 && (n > 60 || $urandom_range(0, 9) == 0))
                    n = $urandom_range(0, (n > 60) ? 60 : n - 1);
                else if ($urandom_range(0, 3) == 0)
                    n = n + $urandom_range(1, 2);
                add_start(x0, y0, x1, y1, 3'($urandom_range(0, 7)));
                add_steps(n);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total || pixel_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_err == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dda_pkg.sv
hdl/dda_div.sv
hdl/dda_pat.sv
hdl/dda_styled_line_rasterizer_core.sv
sim/dda_styled_line_rasterizer_core_tb.sv
